[src/deq_pkg.sv]
// Shared codes and types for the double-ended queue.
package deq_pkg;

  localparam int unsigned OP_W  = 3;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned VAL_W = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_REAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP      = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [ST_W-1:0] ST_ELEMENT   = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic                    vld;
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } result_t;

endpackage

[src/deq_mem.sv]
// Element store: one write port, one read port, registered read data.
module deq_mem import deq_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [$clog2(DEPTH)-1:0]           waddr_i,
  input  logic signed [VAL_W-1:0]            wdata_i,
  input  logic                               re_i,
  input  logic [$clog2(DEPTH)-1:0]           raddr_i,
  output logic signed [VAL_W-1:0]            rdata_o
);

  logic signed [VAL_W-1:0] mem_q [DEPTH];
  logic signed [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/deq_ctrl.sv]
// Pointer bookkeeping, add/remove decisions and the dump read sequencer.
module deq_ctrl import deq_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [OP_W-1:0]               operation_i,
  input  logic signed [VAL_W-1:0]       item_value_i,
  input  logic                          out_free_i,
  output result_t                       res_o,
  output logic                          we_o,
  output logic [$clog2(DEPTH)-1:0]      waddr_o,
  output logic signed [VAL_W-1:0]       wdata_o,
  output logic                          re_o,
  output logic [$clog2(DEPTH)-1:0]      raddr_o,
  input  logic signed [VAL_W-1:0]       rdata_i
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_DUMP = 1'b1;

  logic [0:0]       state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] left_q, left_d;
  logic             pend_q, pend_d;
  logic             pend_last_q, pend_last_d;

  logic             acc;
  logic             consume;
  logic             issue;
  logic [IDX_W-1:0] front_prev;
  logic [IDX_W-1:0] front_next;
  logic [IDX_W-1:0] rd_next;
  logic [SUM_W-1:0] rear_sum;
  logic [SUM_W-1:0] rear_wrap;

  assign in_stall_o = (state_q == S_DUMP) || !out_free_i;
  assign acc        = in_valid_i && !in_stall_o;

  assign front_prev = (front_q == '0) ? IDX_LAST : front_q - 1'b1;
  assign front_next = (front_q == IDX_LAST) ? '0 : front_q + 1'b1;
  assign rd_next    = (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + 1'b1;
  assign rear_sum   = SUM_W'(front_q) + SUM_W'(cnt_q);
  assign rear_wrap  = (rear_sum >= SUM_DEPTH) ? rear_sum - SUM_DEPTH : rear_sum;

  // one read in flight at most; the next is issued as the held data drains
  assign consume = (state_q == S_DUMP) && pend_q && out_free_i;
  assign issue   = (state_q == S_DUMP) && (left_q != '0) && (!pend_q || consume);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    left_d      = left_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    res_o       = '0;
    we_o        = 1'b0;
    waddr_o     = front_prev;
    wdata_o     = item_value_i;
    re_o        = 1'b0;
    raddr_o     = rd_idx_q;

    if (acc) begin
      unique case (operation_i)
        OP_ADD_FRONT: begin
          res_o.vld  = 1'b1;
          res_o.last = 1'b1;
          if (cnt_q == CNT_FULL) begin
            res_o.status = ST_OVERFLOW;
          end else begin
            res_o.status = ST_OK;
            we_o         = 1'b1;
            waddr_o      = front_prev;
            front_d      = front_prev;
            cnt_d        = cnt_q + 1'b1;
          end
        end
        OP_ADD_REAR: begin
          res_o.vld  = 1'b1;
          res_o.last = 1'b1;
          if (cnt_q == CNT_FULL) begin
            res_o.status = ST_OVERFLOW;
          end else begin
            res_o.status = ST_OK;
            we_o         = 1'b1;
            waddr_o      = rear_wrap[IDX_W-1:0];
            cnt_d        = cnt_q + 1'b1;
          end
        end
        OP_REM_FRONT: begin
          res_o.vld  = 1'b1;
          res_o.last = 1'b1;
          if (cnt_q == '0) begin
            res_o.status = ST_UNDERFLOW;
          end else begin
            res_o.status = ST_OK;
            front_d      = front_next;
            cnt_d        = cnt_q - 1'b1;
          end
        end
        OP_REM_REAR: begin
          res_o.vld  = 1'b1;
          res_o.last = 1'b1;
          if (cnt_q == '0) begin
            res_o.status = ST_UNDERFLOW;
          end else begin
            res_o.status = ST_OK;
            cnt_d        = cnt_q - 1'b1;
          end
        end
        OP_DUMP: begin
          if (cnt_q == '0) begin
            res_o.vld    = 1'b1;
            res_o.status = ST_EMPTY;
            res_o.last   = 1'b1;
          end else begin
            state_d  = S_DUMP;
            rd_idx_d = front_q;
            left_d   = cnt_q;
          end
        end
        default: begin
          // unknown operation: no result, no state change
        end
      endcase
    end

    if (consume) begin
      res_o.vld    = 1'b1;
      res_o.status = ST_ELEMENT;
      res_o.value  = rdata_i;
      res_o.last   = pend_last_q;
      pend_d       = 1'b0;
      if (pend_last_q) begin
        state_d = S_IDLE;
      end
    end

    if (issue) begin
      re_o        = 1'b1;
      raddr_o     = rd_idx_q;
      rd_idx_d    = rd_next;
      left_d      = left_q - 1'b1;
      pend_d      = 1'b1;
      pend_last_d = (left_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      left_q      <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      left_q      <= left_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
    end
  end

endmodule

[src/double_ended_queue_core.sv]
// Top level of the bounded double-ended queue with output register.
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+------------------------------------------
//  input   | in_valid_i  | in_stall_o   | operation_i, item_value_i
//  output  | out_valid_o | out_stall_i  | status_o, element_value_o, last_result_o
//
// Each add or removal makes at most one store write and gives one result.
// A dump of n elements streams one element per cycle, while the output is
// not stalled, through the store's single read port; the next item is not
// taken until the last element has been passed to the output register.
// Input is stalled during a dump and while a held result cannot drain.
// Reset empties the queue at once; the store itself is not cleared.
module double_ended_queue_core import deq_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         operation_i,
  input  logic signed [VAL_W-1:0] item_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ST_W-1:0]         status_o,
  output logic signed [VAL_W-1:0] element_value_o,
  output logic                    last_result_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic                    out_vld_q;
  result_t                 out_q;
  result_t                 res;
  logic                    out_free;
  logic                    we;
  logic [IDX_W-1:0]        waddr;
  logic signed [VAL_W-1:0] wdata;
  logic                    re;
  logic [IDX_W-1:0]        raddr;
  logic signed [VAL_W-1:0] rdata;

  assign out_free = !out_vld_q || !out_stall_i;

  deq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .item_value_i(item_value_i),
    .out_free_i  (out_free),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  deq_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= res.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = out_q.status;
  assign element_value_o = out_q.value;
  assign last_result_o   = out_q.last;

endmodule

[src/deq_checker.sv]
// Port-level assertions for the double-ended queue, bound to the top level.
module deq_checker import deq_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic [OP_W-1:0]         operation_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [ST_W-1:0]         status_o,
  input logic signed [VAL_W-1:0] element_value_o,
  input logic                    last_result_o
);

  // a held result does not move while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(element_value_o) && $stable(last_result_o))
    else $error("output item changed while stalled");

  // an accepted add or remove shows its single result in the next cycle
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (operation_i == OP_ADD_FRONT || operation_i == OP_ADD_REAR ||
     operation_i == OP_REM_FRONT || operation_i == OP_REM_REAR)
    |=> out_valid_o && last_result_o && status_o != ST_ELEMENT &&
        status_o != ST_EMPTY)
    else $error("add/remove result missing or malformed");

  // only dumped elements carry a value
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_ELEMENT |-> element_value_o == '0)
    else $error("non-element result carries a value");

  // every non-element result ends its item
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_ELEMENT |-> last_result_o)
    else $error("single result without last flag");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);
